[hdl/fixed_point_q24_8_alu_top_assert.svh]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_assert
// Assertion macros for the fixed-point ALU.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FXA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FXA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FXA_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define FXA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hdl/fxalu_pkg.sv]
// ----------------------------------------------------------------------------
// fxalu_pkg
// Operation codes and default sizes for the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fxalu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_INC      = 4'd10,
    FN_DEC      = 4'd11,
    FN_MIN      = 4'd12,
    FN_MAX      = 4'd13,
    FN_TO_INT   = 4'd14,
    FN_FROM_INT = 4'd15
  } func_e;

endpackage

`default_nettype wire

[hdl/fxalu_if.sv]
// ----------------------------------------------------------------------------
// fxalu_if
// Valid/ready channels carrying operation words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fxalu_in_if #(
  parameter int unsigned WORD_BITS = fxalu_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [3:0]                  func;
  logic signed [WORD_BITS-1:0] operand_a;
  logic signed [WORD_BITS-1:0] operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fxalu_out_if #(
  parameter int unsigned WORD_BITS = fxalu_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] result_value;
  logic                        compare_true;
  logic                        overflowed;
  logic                        divided_by_zero;

  modport source (output valid, result_value, compare_true, overflowed, divided_by_zero,
                  input ready);
  modport sink   (input valid, result_value, compare_true, overflowed, divided_by_zero,
                  output ready);
endinterface

`default_nettype wire

[hdl/fixed_point_q24_8_alu_top.sv]
// Path: stages 1 and 2, divider slots 0..D, output register (Q24.8 default).
// Throughput: one word per cycle unless stalled; one quotient bit per stage.
// Stall: the whole pipe holds while a result waits, so ready drops only then.
// Reset: rst_ni (async, low) clears all valid bits; data regs are not reset.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Pipelined signed fixed-point ALU: add/sub/inc/dec/mul/div/cmp/min/max/convert.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_q24_8_alu_top_assert.svh"

module fixed_point_q24_8_alu_top #(
  parameter int unsigned FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = fxalu_pkg::WORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fxalu_in_if.sink    in_i,
  fxalu_out_if.source out_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned N  = W + F;        // dividend width, also quotient width
  localparam int unsigned D  = N;            // divider stages
  localparam int unsigned PW = 2 * W + 1;    // widest magnitude fed to saturation
  localparam int unsigned H  = W / 2;
  localparam int unsigned LH = W - H;

  localparam logic [W-1:0]  MAXV   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV   = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] LIMPOS = {{(PW-W){1'b0}}, MAXV};
  localparam logic [PW-1:0] LIMNEG = {{(PW-W){1'b0}}, MINV};
  localparam logic [PW-1:0] HALF   = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

  // Signed sum of W+1 bits into the word range: {overflow, value}.
  function automatic logic [W:0] sat_sum(input logic [W:0] s);
    logic o;
    o = s[W] ^ s[W-1];
    return {o, o ? (s[W] ? MINV : MAXV) : s[W-1:0]};
  endfunction

  // Sign and magnitude into the word range: {overflow, value}.
  function automatic logic [W:0] sat_mag(input logic neg, input logic [PW-1:0] m);
    logic [W:0] r;
    if (!neg) begin
      r = (m > LIMPOS) ? {1'b1, MAXV} : {1'b0, m[W-1:0]};
    end else begin
      r = (m > LIMNEG) ? {1'b1, MINV} : {1'b0, W'(~m[W-1:0] + 1'b1)};
    end
    return r;
  endfunction

  // Pipe advances unless a result is stuck in the output register.
  logic vout_q;
  logic en;
  assign en         = !vout_q || out_o.ready;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes, sign, and every operation other than mul and div.
  // --------------------------------------------------------------------------
  logic [W-1:0]  a, b, ma, mb;
  logic          lt, gt, eq;
  logic [W:0]    add_r, sub_r, inc_r, dec_r, from_r;
  logic [W-1:0]  sv_d;
  logic          sc_d, so_d;
  fxalu_pkg::func_e fin;

  assign fin = fxalu_pkg::func_e'(in_i.func);
  assign a   = in_i.operand_a;
  assign b   = in_i.operand_b;
  assign ma  = a[W-1] ? W'(~a + 1'b1) : a;
  assign mb  = b[W-1] ? W'(~b + 1'b1) : b;
  assign lt  = $signed(a) < $signed(b);
  assign gt  = $signed(b) < $signed(a);
  assign eq  = (a == b);

  assign add_r  = sat_sum({a[W-1], a} + {b[W-1], b});
  assign sub_r  = sat_sum({a[W-1], a} - {b[W-1], b});
  assign inc_r  = sat_sum({a[W-1], a} + {{W{1'b0}}, 1'b1});
  assign dec_r  = sat_sum({a[W-1], a} - {{W{1'b0}}, 1'b1});
  assign from_r = sat_mag(a[W-1], PW'({ma, {F{1'b0}}}));

  always_comb begin
    sv_d = '0;
    sc_d = 1'b0;
    so_d = 1'b0;
    case (fin)
      fxalu_pkg::FN_ADD:      {so_d, sv_d} = add_r;
      fxalu_pkg::FN_SUB:      {so_d, sv_d} = sub_r;
      fxalu_pkg::FN_GT:       sc_d = gt;
      fxalu_pkg::FN_LT:       sc_d = lt;
      fxalu_pkg::FN_GE:       sc_d = !lt;
      fxalu_pkg::FN_LE:       sc_d = !gt;
      fxalu_pkg::FN_EQ:       sc_d = eq;
      fxalu_pkg::FN_NE:       sc_d = !eq;
      fxalu_pkg::FN_INC:      {so_d, sv_d} = inc_r;
      fxalu_pkg::FN_DEC:      {so_d, sv_d} = dec_r;
      fxalu_pkg::FN_MIN:      sv_d = lt ? a : b;
      fxalu_pkg::FN_MAX:      sv_d = gt ? a : b;
      fxalu_pkg::FN_TO_INT:   sv_d = W'($signed(a) >>> F);
      fxalu_pkg::FN_FROM_INT: {so_d, sv_d} = from_r;
      default: begin
        sv_d = '0;   // mul and div finish further down
      end
    endcase
  end

  logic             v1_q, neg1_q, sc1_q, so1_q, bz1_q;
  fxalu_pkg::func_e f1_q;
  logic [W-1:0]     ma1_q, mb1_q, sv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= fin;
      neg1_q <= a[W-1] ^ b[W-1];
      ma1_q  <= ma;
      mb1_q  <= mb;
      sv1_q  <= sv_d;
      sc1_q  <= sc_d;
      so1_q  <= so_d;
      bz1_q  <= (b == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitude product as two half-width partial products.
  // --------------------------------------------------------------------------
  logic             v2_q, neg2_q, sc2_q, so2_q, bz2_q;
  fxalu_pkg::func_e f2_q;
  logic [W-1:0]     ma2_q, mb2_q, sv2_q;
  logic [W+H-1:0]   plo2_q;
  logic [W+LH-1:0]  phi2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q   <= f1_q;
      neg2_q <= neg1_q;
      ma2_q  <= ma1_q;
      mb2_q  <= mb1_q;
      sv2_q  <= sv1_q;
      sc2_q  <= sc1_q;
      so2_q  <= so1_q;
      bz2_q  <= bz1_q;
      plo2_q <= (W+H)'(ma1_q) * (W+H)'(mb1_q[H-1:0]);
      phi2_q <= (W+LH)'(ma1_q) * (W+LH)'(mb1_q[W-1:H]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 (divider slot 0): finish mul with rounding, seed the divider.
  // Slots 1..D: one restoring quotient bit each. Dividend and quotient share
  // one shift register: the top bit leaves, the new quotient bit enters.
  // --------------------------------------------------------------------------
  logic [2*W-1:0] prod;
  logic [PW-1:0]  prod_rnd;
  logic [W:0]     mul_r;

  assign prod     = (2*W)'(plo2_q) + ((2*W)'(phi2_q) << H);
  assign prod_rnd = ({1'b0, prod} + HALF) >> F;
  assign mul_r    = sat_mag(neg2_q, prod_rnd);

  logic             dv_q  [0:D];
  fxalu_pkg::func_e df_q  [0:D];
  logic             dneg_q[0:D];
  logic [W-1:0]     dmb_q [0:D];
  logic [W-1:0]     drem_q[0:D];
  logic [N-1:0]     dnq_q [0:D];
  logic [W-1:0]     dsv_q [0:D];
  logic             dsc_q [0:D];
  logic             dso_q [0:D];
  logic             dbz_q [0:D];
  logic [W-1:0]     dmv_q [0:D];
  logic             dmo_q [0:D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      df_q[0]   <= f2_q;
      dneg_q[0] <= neg2_q;
      dmb_q[0]  <= mb2_q;
      drem_q[0] <= '0;
      dnq_q[0]  <= {ma2_q, {F{1'b0}}};
      dsv_q[0]  <= sv2_q;
      dsc_q[0]  <= sc2_q;
      dso_q[0]  <= so2_q;
      dbz_q[0]  <= bz2_q;
      {dmo_q[0], dmv_q[0]} <= mul_r;
    end
  end

  for (genvar k = 1; k <= D; k++) begin : g_div
    logic [W:0] trial;
    logic       fits;

    assign trial = {drem_q[k-1], dnq_q[k-1][N-1]};
    assign fits  = trial >= {1'b0, dmb_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[k] <= fits ? W'(trial - {1'b0, dmb_q[k-1]}) : trial[W-1:0];
        dnq_q[k]  <= {dnq_q[k-1][N-2:0], fits};
        df_q[k]   <= df_q[k-1];
        dneg_q[k] <= dneg_q[k-1];
        dmb_q[k]  <= dmb_q[k-1];
        dsv_q[k]  <= dsv_q[k-1];
        dsc_q[k]  <= dsc_q[k-1];
        dso_q[k]  <= dso_q[k-1];
        dbz_q[k]  <= dbz_q[k-1];
        dmv_q[k]  <= dmv_q[k-1];
        dmo_q[k]  <= dmo_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: round the quotient (half away from zero), pick the result.
  // --------------------------------------------------------------------------
  logic          rnd_up;
  logic [PW-1:0] quo_rnd;
  logic [W:0]    div_r;

  assign rnd_up  = drem_q[D] >= W'(dmb_q[D] - drem_q[D]);
  assign quo_rnd = PW'(dnq_q[D]) + PW'(rnd_up);
  assign div_r   = sat_mag(dneg_q[D], quo_rnd);

  logic [W-1:0] value_d, value_q;
  logic         cmp_d, cmp_q, ovf_d, ovf_q, dz_d, dz_q;

  always_comb begin
    value_d = dsv_q[D];
    cmp_d   = dsc_q[D];
    ovf_d   = dso_q[D];
    dz_d    = 1'b0;
    case (df_q[D])
      fxalu_pkg::FN_MUL: begin
        value_d = dmv_q[D];
        ovf_d   = dmo_q[D];
      end
      fxalu_pkg::FN_DIV: begin
        if (dbz_q[D]) begin
          value_d = '0;
          ovf_d   = 1'b0;
          dz_d    = 1'b1;
        end else begin
          {ovf_d, value_d} = div_r;
        end
      end
      default: begin
        value_d = dsv_q[D];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= dv_q[D];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= value_d;
      cmp_q   <= cmp_d;
      ovf_q   <= ovf_d;
      dz_q    <= dz_d;
    end
  end

  assign out_o.valid           = vout_q;
  assign out_o.result_value    = value_q;
  assign out_o.compare_true    = cmp_q;
  assign out_o.overflowed      = ovf_q;
  assign out_o.divided_by_zero = dz_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FXA_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_i.valid && en, v1_q)
  `FXA_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en, $stable(v1_q) && $stable(v2_q))
  `FXA_ASSERT_NOW(a_dz_clean, clk_i, rst_ni, vout_q && dz_q, !ovf_q && (value_q == '0))
  `FXA_ASSERT_NOW(a_cmp_clean, clk_i, rst_ni, vout_q && cmp_q,
                  !ovf_q && !dz_q && (value_q == '0))

endmodule

`default_nettype wire

[dv/fixed_point_q24_8_alu_top_tb.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_tb
// Self-checking bench for the Q24.8 ALU: directed corner words, then random
// words under three idle patterns, each result checked against a typed row or a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_q24_8_alu_top_tb;

  localparam int unsigned FRAC = fxalu_pkg::FRAC_BITS_DEF;
  localparam int unsigned WBITS = fxalu_pkg::WORD_BITS_DEF;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;
  localparam int DRAIN_CYCLES = 120;   // pipe depth is 44
  localparam int STALL_LIMIT = 4000;   // cycles with no word moving
  localparam int RAND_PER_PHASE = 380;

  // One ALU result, as the block reports it.
  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               ovf;
    logic               dz;
  } alu_res_t;

  typedef struct {
    fxalu_pkg::func_e   fn;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 typed;   // expectation given in the row
    alu_res_t           res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fxalu_in_if  #(.WORD_BITS(WBITS)) in_bus ();
  fxalu_out_if #(.WORD_BITS(WBITS)) out_bus ();

  fixed_point_q24_8_alu_top #(.FRAC_BITS(FRAC), .WORD_BITS(WBITS)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  alu_res_t pending_results[$];
  int       mismatches = 0;
  int       send_idle_pct = 22;
  int       recv_idle_pct = 51;
  int       quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Saturate a sign and magnitude into the 32-bit range.
  function automatic logic signed [31:0] sat_mag(bit neg, logic [127:0] m, ref bit ovf);
    if (!neg) begin
      if (m > 128'h7fffffff) begin
        ovf = 1'b1;
        return WMAX;
      end
      return m[31:0];
    end
    if (m > 128'h80000000) begin
      ovf = 1'b1;
      return WMIN;
    end
    return -m[31:0];
  endfunction

  function automatic logic signed [31:0] sat_long(longint s, ref bit ovf);
    if (s > longint'(WMAX)) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (s < longint'(WMIN)) begin
      ovf = 1'b1;
      return WMIN;
    end
    return s[31:0];
  endfunction

  function automatic logic [127:0] mag_of(logic signed [31:0] v);
    longint l;
    l = v;
    if (l < 0) l = -l;
    return 128'(l);
  endfunction

  function automatic alu_res_t predict_alu(fxalu_pkg::func_e fn, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t    r;
    bit          ovf;
    bit          neg;
    logic [127:0] p;
    logic [127:0] q;
    logic [127:0] rm;
    r   = '0;
    ovf = 1'b0;
    neg = (a < 0) != (b < 0);
    case (fn)
      fxalu_pkg::FN_ADD: r.value = sat_long(longint'(a) + longint'(b), ovf);
      fxalu_pkg::FN_SUB: r.value = sat_long(longint'(a) - longint'(b), ovf);
      fxalu_pkg::FN_INC: r.value = sat_long(longint'(a) + 1, ovf);
      fxalu_pkg::FN_DEC: r.value = sat_long(longint'(a) - 1, ovf);
      fxalu_pkg::FN_MUL: begin
        // exact product, half-unit added to the magnitude: ties go away from zero
        p = mag_of(a) * mag_of(b) + (128'd1 << (FRAC - 1));
        r.value = sat_mag(neg, p >> FRAC, ovf);
      end
      fxalu_pkg::FN_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          p  = mag_of(a) << FRAC;
          q  = p / mag_of(b);
          rm = p % mag_of(b);
          if (2 * rm >= mag_of(b)) q = q + 1;
          r.value = sat_mag(neg, q, ovf);
        end
      end
      fxalu_pkg::FN_GT: r.cmp = a > b;
      fxalu_pkg::FN_LT: r.cmp = a < b;
      fxalu_pkg::FN_GE: r.cmp = a >= b;
      fxalu_pkg::FN_LE: r.cmp = a <= b;
      fxalu_pkg::FN_EQ: r.cmp = a == b;
      fxalu_pkg::FN_NE: r.cmp = a != b;
      fxalu_pkg::FN_MIN: r.value = (a < b) ? a : b;
      fxalu_pkg::FN_MAX: r.value = (b < a) ? a : b;
      fxalu_pkg::FN_TO_INT: r.value = a >>> FRAC;   // floors toward minus infinity
      fxalu_pkg::FN_FROM_INT: r.value = sat_mag(a < 0, mag_of(a) << FRAC, ovf);
      default: r = '0;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: typed expectations only where obvious
  // --------------------------------------------------------------------------
  stim_row_t corner_rows[] = '{
    '{fxalu_pkg::FN_ADD, WMAX, 32'sd1, 1, '{WMAX, 1'b0, 1'b1, 1'b0}},  // positive saturation
    '{fxalu_pkg::FN_SUB, WMIN, 32'sd1, 1, '{WMIN, 1'b0, 1'b1, 1'b0}},  // negative saturation
    '{fxalu_pkg::FN_ADD, WMIN, WMIN, 1, '{WMIN, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_SUB, 32'sd0, WMIN, 1, '{WMAX, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_MUL, 32'sd256, 32'sd256, 1, '{32'sd256, 1'b0, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_MUL, 32'sd1, 32'sd128, 1, '{32'sd1, 1'b0, 1'b0, 1'b0}},   // tie up
    '{fxalu_pkg::FN_MUL, -32'sd1, 32'sd128, 1, '{-32'sd1, 1'b0, 1'b0, 1'b0}}, // tie down
    '{fxalu_pkg::FN_MUL, WMAX, WMAX, 1, '{WMAX, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_MUL, WMIN, WMAX, 1, '{WMIN, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_DIV, 32'sd12345, 32'sd0, 1, '{32'sd0, 1'b0, 1'b0, 1'b1}}, // div by zero
    '{fxalu_pkg::FN_DIV, WMIN, 32'sd0, 1, '{32'sd0, 1'b0, 1'b0, 1'b1}},
    '{fxalu_pkg::FN_DIV, WMAX, 32'sd1, 1, '{WMAX, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_DIV, 32'sd1, 32'sd512, 0, '0},               // half, away from zero
    '{fxalu_pkg::FN_DIV, WMIN, -32'sd256, 0, '0},
    '{fxalu_pkg::FN_GT, WMAX, WMIN, 1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_LT, WMAX, WMIN, 1, '{32'sd0, 1'b0, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_GE, 32'sd7, 32'sd7, 1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_LE, WMIN, WMIN, 1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_EQ, -32'sd5, -32'sd5, 1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_NE, -32'sd5, -32'sd5, 1, '{32'sd0, 1'b0, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_INC, WMAX, 32'sd0, 1, '{WMAX, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_DEC, WMIN, 32'sd0, 1, '{WMIN, 1'b0, 1'b1, 1'b0}},
    '{fxalu_pkg::FN_MIN, 32'sd9, 32'sd9, 1, '{32'sd9, 1'b0, 1'b0, 1'b0}},   // equal operands
    '{fxalu_pkg::FN_MAX, WMIN, WMAX, 1, '{WMAX, 1'b0, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_TO_INT, -32'sd1, 32'sd0, 1, '{-32'sd1, 1'b0, 1'b0, 1'b0}},
    '{fxalu_pkg::FN_FROM_INT, WMIN, 32'sd0, 1, '{WMIN, 1'b0, 1'b1, 1'b0}}
  };

  // --------------------------------------------------------------------------
  // Source side: drive one word at the falling edge, hold until accepted
  // --------------------------------------------------------------------------
  task automatic send_word(fxalu_pkg::func_e fn, logic signed [31:0] a,
                           logic signed [31:0] b, bit typed, alu_res_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     = 1'b1;
    in_bus.func      = fn;
    in_bus.operand_a = a;
    in_bus.operand_b = b;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_results.push_back(typed ? res : predict_alu(fn, a, b));
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return WMAX - $urandom_range(0, 3);
      1: return WMIN + $urandom_range(0, 3);
      2: return $urandom_range(0, 1023) - 512;            // near zero, ties likely
      3: return ($urandom_range(0, 255) - 128) * 256;     // whole numbers
      4: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    fxalu_pkg::func_e fn;
    logic signed [31:0] a;
    logic signed [31:0] b;
    in_bus.valid     = 1'b0;
    in_bus.func      = fxalu_pkg::FN_ADD;
    in_bus.operand_a = '0;
    in_bus.operand_b = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (corner_rows[i])
      send_word(corner_rows[i].fn, corner_rows[i].a, corner_rows[i].b,
                corner_rows[i].typed, corner_rows[i].res);
    for (int phase = 0; phase < 3; phase++) begin
      // idle pattern per phase: sink-heavy, then swapped, then back-to-back
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        fn = fxalu_pkg::func_e'($urandom_range(0, 15));
        a  = pick_operand();
        b  = pick_operand();
        if ($urandom_range(0, 9) == 0) b = a;   // equal operands now and then
        send_word(fn, a, b, 1'b0, '0);
      end
    end
    in_bus.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink side: random backpressure, change at falling edge
  // --------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker and watchdog, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alu_res_t got;
    alu_res_t want;
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.result_value, out_bus.compare_true, out_bus.overflowed,
                out_bus.divided_by_zero};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp val=%h cmp=%b ovf=%b dz=%b,",
                        " got val=%h cmp=%b ovf=%b dz=%b"},
                       want.value, want.cmp, want.ovf, want.dz,
                       got.value, got.cmp, got.ovf, got.dz);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
